// ===== sv/ckg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckg_pkg
// Shared constants, types and elaboration-time tables for the chroma-key
// composite with gamma correction.
// ----------------------------------------------------------------------------
package ckg_pkg;

	localparam int F        = 16;
	localparam int ONE      = 1 << F;
	localparam int MAG_W    = F + 5;
	localparam int PROD_W   = 29;
	localparam int LVL_W    = F + 1;
	localparam int CV_W     = F + 2;
	localparam int E_W      = PROD_W - 6;
	localparam int K_W      = E_W - F;
	localparam int KS_W     = $clog2(F + 2);
	localparam int CORR_LAT = F + 9;
	localparam int DIV_LAT  = 8;

	localparam int D100_S = 29;
	localparam logic [22:0] D100_M = 23'((64'd1 << D100_S) / 100);

	typedef enum logic [2:0] {
		REG_CONTRAST   = 3'd0,
		REG_BRIGHTNESS = 3'd1,
		REG_GAMMA      = 3'd2,
		REG_VALUE_ONLY = 3'd3,
		REG_HUE_BOUNDS = 3'd4,
		REG_SAT_BOUNDS = 3'd5,
		REG_VAL_BOUNDS = 3'd6
	} ckg_reg_t;

	typedef enum logic [1:0] {
		MAX_RED   = 2'd0,
		MAX_GREEN = 2'd1,
		MAX_BLUE  = 2'd2
	} ckg_max_t;

	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} ckg_sec_t;

	typedef struct packed {
		logic [7:0]       contrast;
		logic [7:0]       gamma;
		logic [LVL_W-1:0] boff;
		logic             boff_neg;
	} ckg_corr_cfg_t;

	typedef logic [MAG_W-1:0] mag_tbl_t [256];
	typedef logic [F:0]       pow_tbl_t [1:F];

	// reciprocal estimate of n/100, low by at most one
	function automatic logic [PROD_W-1:0] div100_est(input logic [PROD_W-1:0] n);
		logic [PROD_W+22:0] pr;
		pr = (PROD_W+23)'(n) * (PROD_W+23)'(D100_M);
		return PROD_W'(pr >> D100_S);
	endfunction

	function automatic logic [PROD_W-1:0] div100_fix(input logic [PROD_W-1:0] n,
			input logic [PROD_W-1:0] q0);
		logic [PROD_W-1:0] rem;
		rem = n - q0 * PROD_W'(100);
		return (rem >= PROD_W'(100)) ? q0 + PROD_W'(1) : q0;
	endfunction

	function automatic longint unsigned isqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		longint unsigned w;
		r = 0;
		w = v;
		b = 64'd1 << 62;
		while (b > w) b = b >> 2;
		while (b != 0) begin
			if (w >= r + b) begin
				w = w - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// magnitude of log2(x/255) in UQ.F for every nonzero 8-bit level; entry 0 is zero
	function automatic mag_tbl_t build_mag();
		mag_tbl_t tb;
		longint unsigned t;
		longint unsigned m;
		longint unsigned frac;
		int n;
		tb[0] = '0;
		for (int x = 1; x < 256; x++) begin
			t = (64'(x) * 64'(ONE) + 64'd127) / 255;
			if (t == 0) t = 1;
			n = 0;
			while ((t >> (n + 1)) != 0) n++;
			m = t << (F - n);
			frac = 0;
			for (int i = 1; i <= F; i++) begin
				m = (m * m) >> F;
				if (m >= 64'(2 * ONE)) begin
					m = m >> 1;
					frac = frac | (64'd1 << (F - i));
				end
			end
			tb[x] = MAG_W'(64'(F - n) * 64'(ONE) - frac);
		end
		return tb;
	endfunction

	// factors 2^-(2^-i) from a chain of floor square roots
	function automatic pow_tbl_t build_pow();
		pow_tbl_t tb;
		longint unsigned a;
		a = isqrt(64'(ONE / 2) << F);
		for (int i = 1; i <= F; i++) begin
			tb[i] = (F+1)'(a);
			a = isqrt(a << F);
		end
		return tb;
	endfunction

	localparam mag_tbl_t MAG_TBL = build_mag();
	localparam pow_tbl_t POW_TBL = build_pow();

endpackage

// ===== sv/ckg_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckg_in_if
// Input pixel channel: foreground and background BGR pair.
// ----------------------------------------------------------------------------
interface ckg_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] fg_blue;
	logic [7:0] fg_green;
	logic [7:0] fg_red;
	logic [7:0] bg_blue;
	logic [7:0] bg_green;
	logic [7:0] bg_red;

	modport source (output valid, fg_blue, fg_green, fg_red, bg_blue, bg_green, bg_red,
		input ready);
	modport sink (input valid, fg_blue, fg_green, fg_red, bg_blue, bg_green, bg_red,
		output ready);
endinterface

// ===== sv/ckg_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckg_out_if
// Output pixel channel: composited BGR pixel and key flag.
// ----------------------------------------------------------------------------
interface ckg_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_blue;
	logic [7:0] out_green;
	logic [7:0] out_red;
	logic       keyed;

	modport source (output valid, out_blue, out_green, out_red, keyed, input ready);
	modport sink (input valid, out_blue, out_green, out_red, keyed, output ready);
endinterface

// ===== sv/ckg_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckg_div
// Pipelined restoring divider, one quotient bit per stage, 8-bit quotient.
// ----------------------------------------------------------------------------
module ckg_div (
	input  logic        clk,
	input  logic        en,
	input  logic [16:0] num,
	input  logic [8:0]  den,
	output logic [7:0]  quo
);
	localparam int N = ckg_pkg::DIV_LAT;

	logic [16:0] rem_s [1:N];
	logic [8:0]  den_s [1:N];
	logic [7:0]  q_s   [1:N];

	for (genvar j = 1; j <= N; j++) begin : g_stage
		logic [16:0] rem_p;
		logic [8:0]  den_p;
		logic [7:0]  q_p;
		logic [16:0] trial;
		if (j == 1) begin : g_first
			assign rem_p = num;
			assign den_p = den;
			assign q_p   = '0;
		end else begin : g_next
			assign rem_p = rem_s[j-1];
			assign den_p = den_s[j-1];
			assign q_p   = q_s[j-1];
		end
		assign trial = 17'(den_p) << (N - j);
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j] <= den_p;
				if (rem_p >= trial) begin
					rem_s[j] <= rem_p - trial;
					q_s[j]   <= q_p | (8'd1 << (N - j));
				end else begin
					rem_s[j] <= rem_p;
					q_s[j]   <= q_p;
				end
			end
		end
	end

	assign quo = q_s[N];
endmodule

// ===== sv/ckg_corr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckg_corr
// Level correction c*x^g+b: log2 table, gamma scale, exp2 by a chain of
// root factors, contrast, brightness, clamp and rescale to 8 bits.
// ----------------------------------------------------------------------------
module ckg_corr (
	input  logic                   clk,
	input  logic                   en,
	input  logic [7:0]             x,
	input  ckg_pkg::ckg_corr_cfg_t cfg,
	output logic [7:0]             level
);
	localparam int F      = ckg_pkg::F;
	localparam int PROD_W = ckg_pkg::PROD_W;
	localparam int E_W    = ckg_pkg::E_W;
	localparam int K_W    = ckg_pkg::K_W;
	localparam int KS_W   = ckg_pkg::KS_W;
	localparam int CV_W   = ckg_pkg::CV_W;

	logic [ckg_pkg::MAG_W-1:0] mag_s1;
	logic                      z_s1;
	logic [PROD_W-1:0]         prod_s2;
	logic                      z_s2;
	logic [PROD_W-1:0]         n_s3, q0_s3;
	logic                      z_s3;
	logic [E_W-1:0]            e_s4;
	logic                      z_s4;

	logic [F:0]     r_s [1:F];
	logic [F-1:0]   f_s [1:F];
	logic [K_W-1:0] k_s [1:F];
	logic           z_s [1:F];

	logic [F:0]        p_c;
	logic [F+1:0]      rnd;
	logic [KS_W-1:0]   ks;
	logic [F:0]        p_s21;
	logic [PROD_W-1:0] cvn_s22;
	logic [PROD_W-1:0] cvn_s23, cvq_s23;
	logic [CV_W-1:0]   cv_s24;
	logic [CV_W:0]     sum;
	logic [CV_W:0]     sat;
	logic [CV_W+8:0]   scaled;
	logic [7:0]        level_s25;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= ckg_pkg::MAG_TBL[x];
			z_s1    <= (x == 8'd0);
			prod_s2 <= PROD_W'(mag_s1) * PROD_W'(cfg.gamma) + PROD_W'(50);
			z_s2    <= z_s1;
			n_s3    <= prod_s2;
			q0_s3   <= ckg_pkg::div100_est(prod_s2);
			z_s3    <= z_s2;
			e_s4    <= E_W'(ckg_pkg::div100_fix(n_s3, q0_s3));
			z_s4    <= z_s3;
		end
	end

	// one root factor per stage, applied where the exponent fraction bit is set
	for (genvar i = 1; i <= F; i++) begin : g_pow
		logic [F:0]     r_p;
		logic [F-1:0]   f_p;
		logic [K_W-1:0] k_p;
		logic           z_p;
		logic [2*F+1:0] pr;
		if (i == 1) begin : g_first
			assign r_p = (F+1)'(ckg_pkg::ONE);
			assign f_p = e_s4[F-1:0];
			assign k_p = e_s4[E_W-1:F];
			assign z_p = z_s4;
		end else begin : g_next
			assign r_p = r_s[i-1];
			assign f_p = f_s[i-1];
			assign k_p = k_s[i-1];
			assign z_p = z_s[i-1];
		end
		assign pr = (2*F+2)'(r_p) * (2*F+2)'(ckg_pkg::POW_TBL[i])
			+ (2*F+2)'(ckg_pkg::ONE / 2);
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[i] <= f_p[F-i] ? (F+1)'(pr >> F) : r_p;
				f_s[i] <= f_p;
				k_s[i] <= k_p;
				z_s[i] <= z_p;
			end
		end
	end

	// integer part of the exponent as a rounding right shift
	assign ks = k_s[F][KS_W-1:0];
	always_comb begin
		rnd = '0;
		if (z_s[F]) begin
			p_c = (cfg.gamma == 8'd0) ? (F+1)'(ckg_pkg::ONE) : '0;
		end else if (k_s[F] == '0) begin
			p_c = r_s[F];
		end else if (k_s[F] >= K_W'(F + 2)) begin
			p_c = '0;
		end else begin
			rnd = (F+2)'(r_s[F]) + ((F+2)'(1) << (ks - KS_W'(1)));
			p_c = (F+1)'(rnd >> ks);
		end
	end

	always_comb begin
		if (cfg.boff_neg) begin
			sum = (cv_s24 >= CV_W'(cfg.boff)) ? (CV_W+1)'(cv_s24 - CV_W'(cfg.boff)) : '0;
		end else begin
			sum = (CV_W+1)'(cv_s24) + (CV_W+1)'(cfg.boff);
		end
		sat    = (sum > (CV_W+1)'(ckg_pkg::ONE)) ? (CV_W+1)'(ckg_pkg::ONE) : sum;
		scaled = ((CV_W+9)'(sat) << 8) - (CV_W+9)'(sat) + (CV_W+9)'(ckg_pkg::ONE / 2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s21     <= p_c;
			cvn_s22   <= PROD_W'(cfg.contrast) * PROD_W'(p_s21) + PROD_W'(50);
			cvn_s23   <= cvn_s22;
			cvq_s23   <= ckg_pkg::div100_est(cvn_s22);
			cv_s24    <= CV_W'(ckg_pkg::div100_fix(cvn_s23, cvq_s23));
			level_s25 <= 8'(scaled >> F);
		end
	end

	assign level = level_s25;
endmodule

// ===== sv/chroma_key_gamma_composite_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chroma_key_gamma_composite_unit
// Chroma-key composite: HSV key test on the foreground, background pass on a
// key hit, otherwise gamma/contrast/brightness correction of BGR or of V.
// Pipeline from input transfer to result: 3 front stages, 8 divider stages,
// 1 key stage, 25 correction stages, 6 HSV-to-BGR stages.
// Throughput: one pixel per cycle; the whole pipeline holds while the output
// register is full and not taken.
// Reset: asynchronous active-low; clears pipeline valid bits and loads the
// register defaults. No clearing pass.
// ----------------------------------------------------------------------------
module chroma_key_gamma_composite_unit (
	input  logic        clk,
	input  logic        arst_n,
	ckg_in_if.sink      pix_in,
	ckg_out_if.source   pix_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int F      = ckg_pkg::F;
	localparam int PROD_W = ckg_pkg::PROD_W;
	localparam int LVL_W  = ckg_pkg::LVL_W;
	localparam int DL     = ckg_pkg::DIV_LAT;
	localparam int CL     = ckg_pkg::CORR_LAT;
	localparam int TOT    = 3 + DL + 1 + CL + 6;

	typedef struct packed {
		logic [7:0] fb, fg, fr, bb, bg, br, mx;
		logic       dz, mz;
	} hsv_side_t;

	typedef struct packed {
		logic [7:0] h, s, bb, bg, br;
		logic       key;
	} corr_side_t;

	typedef struct packed {
		logic       key;
		logic [7:0] bb, bg, br, lb, lg, lr;
	} tail_t;

	// configuration
	logic [7:0]        contrast_q, brightness_q, gamma_q;
	logic              vmode_q;
	logic [15:0]       hue_bnd_q, sat_bnd_q, val_bnd_q;
	logic [7:0]        bmag;
	logic [PROD_W-1:0] bn_q, bq0_q;
	logic [LVL_W-1:0]  boff_q;
	logic              bneg_q;
	ckg_pkg::ckg_corr_cfg_t corr_cfg;
	ckg_pkg::ckg_reg_t      ridx;
	logic              wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign ridx   = ckg_pkg::ckg_reg_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			contrast_q   <= 8'd100;
			brightness_q <= 8'd100;
			gamma_q      <= 8'd100;
			vmode_q      <= 1'b0;
			hue_bnd_q    <= '0;
			sat_bnd_q    <= '0;
			val_bnd_q    <= '0;
		end else if (wr) begin
			case (ridx)
				ckg_pkg::REG_CONTRAST:   contrast_q   <= pwdata[7:0];
				ckg_pkg::REG_BRIGHTNESS: brightness_q <= pwdata[7:0];
				ckg_pkg::REG_GAMMA:      gamma_q      <= pwdata[7:0];
				ckg_pkg::REG_VALUE_ONLY: vmode_q      <= pwdata[0];
				ckg_pkg::REG_HUE_BOUNDS: hue_bnd_q    <= pwdata[15:0];
				ckg_pkg::REG_SAT_BOUNDS: sat_bnd_q    <= pwdata[15:0];
				ckg_pkg::REG_VAL_BOUNDS: val_bnd_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			ckg_pkg::REG_CONTRAST:   prdata = 32'(contrast_q);
			ckg_pkg::REG_BRIGHTNESS: prdata = 32'(brightness_q);
			ckg_pkg::REG_GAMMA:      prdata = 32'(gamma_q);
			ckg_pkg::REG_VALUE_ONLY: prdata = 32'(vmode_q);
			ckg_pkg::REG_HUE_BOUNDS: prdata = 32'(hue_bnd_q);
			ckg_pkg::REG_SAT_BOUNDS: prdata = 32'(sat_bnd_q);
			ckg_pkg::REG_VAL_BOUNDS: prdata = 32'(val_bnd_q);
			default:                 prdata = '0;
		endcase
	end

	// brightness offset, settles long before any pixel reaches the adder
	assign bmag = (brightness_q >= 8'd100) ? brightness_q - 8'd100 : 8'd100 - brightness_q;
	always_ff @(posedge clk) begin
		bn_q   <= (PROD_W'(bmag) << F) + PROD_W'(50);
		bq0_q  <= ckg_pkg::div100_est(bn_q);
		boff_q <= LVL_W'(ckg_pkg::div100_fix(bn_q, bq0_q));
		bneg_q <= (brightness_q < 8'd100);
	end

	assign corr_cfg = '{contrast: contrast_q, gamma: gamma_q, boff: boff_q, boff_neg: bneg_q};

	// pipeline control
	logic [TOT:1] vld_s;
	logic         en;

	assign en           = ~vld_s[TOT] | pix_out.ready;
	assign pix_in.ready = en;
	assign pix_out.valid = vld_s[TOT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[TOT-1:1], pix_in.valid};
		end
	end

	// s1 input register
	logic [7:0] fb_s1, fg_s1, fr_s1, bb_s1, bg_s1, br_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			fb_s1 <= pix_in.fg_blue;
			fg_s1 <= pix_in.fg_green;
			fr_s1 <= pix_in.fg_red;
			bb_s1 <= pix_in.bg_blue;
			bg_s1 <= pix_in.bg_green;
			br_s1 <= pix_in.bg_red;
		end
	end

	// s2 max, min and which channel holds the max
	logic [7:0] mx_c, mn_c;
	ckg_pkg::ckg_max_t sel_c;
	logic [7:0] fb_s2, fg_s2, fr_s2, bb_s2, bg_s2, br_s2, mx_s2, diff_s2;
	ckg_pkg::ckg_max_t sel_s2;

	always_comb begin
		mx_c = fr_s1;
		if (fg_s1 > mx_c) mx_c = fg_s1;
		if (fb_s1 > mx_c) mx_c = fb_s1;
		mn_c = fr_s1;
		if (fg_s1 < mn_c) mn_c = fg_s1;
		if (fb_s1 < mn_c) mn_c = fb_s1;
		if (mx_c == fr_s1)      sel_c = ckg_pkg::MAX_RED;
		else if (mx_c == fg_s1) sel_c = ckg_pkg::MAX_GREEN;
		else                    sel_c = ckg_pkg::MAX_BLUE;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fb_s2   <= fb_s1;
			fg_s2   <= fg_s1;
			fr_s2   <= fr_s1;
			bb_s2   <= bb_s1;
			bg_s2   <= bg_s1;
			br_s2   <= br_s1;
			mx_s2   <= mx_c;
			diff_s2 <= mx_c - mn_c;
			sel_s2  <= sel_c;
		end
	end

	// s3 hue numerator in units of two degrees times diff
	logic [15:0] num_c, d16;
	logic [16:0] nh_s3, ns_s3;
	logic [8:0]  dh_s3, ds_s3;
	hsv_side_t   side_s3;

	assign d16 = 16'(diff_s2);
	always_comb begin
		case (sel_s2)
			ckg_pkg::MAX_RED:
				num_c = (fg_s2 >= fb_s2) ? 16'd30 * 16'(fg_s2 - fb_s2)
					: 16'd180 * d16 - 16'd30 * 16'(fb_s2 - fg_s2);
			ckg_pkg::MAX_GREEN:
				num_c = (fb_s2 >= fr_s2) ? 16'd60 * d16 + 16'd30 * 16'(fb_s2 - fr_s2)
					: 16'd60 * d16 - 16'd30 * 16'(fr_s2 - fb_s2);
			default:
				num_c = (fr_s2 >= fg_s2) ? 16'd120 * d16 + 16'd30 * 16'(fr_s2 - fg_s2)
					: 16'd120 * d16 - 16'd30 * 16'(fg_s2 - fr_s2);
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nh_s3   <= {num_c, 1'b0} + 17'(diff_s2);
			dh_s3   <= {diff_s2, 1'b0};
			ns_s3   <= 17'(diff_s2) * 17'd510 + 17'(mx_s2);
			ds_s3   <= {mx_s2, 1'b0};
			side_s3 <= '{fb: fb_s2, fg: fg_s2, fr: fr_s2, bb: bb_s2, bg: bg_s2, br: br_s2,
				mx: mx_s2, dz: (diff_s2 == 8'd0), mz: (mx_s2 == 8'd0)};
		end
	end

	// rounded divisions for hue and saturation
	logic [7:0] hq, sq;
	ckg_div u_div_hue (.clk(clk), .en(en), .num(nh_s3), .den(dh_s3), .quo(hq));
	ckg_div u_div_sat (.clk(clk), .en(en), .num(ns_s3), .den(ds_s3), .quo(sq));

	hsv_side_t hsd_s [1:DL];
	always_ff @(posedge clk) begin
		if (en) begin
			hsd_s[1] <= side_s3;
			for (int i = 2; i <= DL; i++) hsd_s[i] <= hsd_s[i-1];
		end
	end

	// s4 hsv and key decision
	logic [7:0] h_c, s_c;
	logic       key_c;
	logic [7:0] h_s4, s_s4, v_s4, fb_s4, fg_s4, fr_s4, bb_s4, bg_s4, br_s4;
	logic       key_s4;

	always_comb begin
		if (hsd_s[DL].dz)        h_c = '0;
		else if (hq >= 8'd180)   h_c = hq - 8'd180;
		else                     h_c = hq;
		s_c = hsd_s[DL].mz ? 8'd0 : sq;
		key_c = (h_c >= hue_bnd_q[7:0]) && (h_c <= hue_bnd_q[15:8])
			&& (s_c >= sat_bnd_q[7:0]) && (s_c <= sat_bnd_q[15:8])
			&& (hsd_s[DL].mx >= val_bnd_q[7:0]) && (hsd_s[DL].mx <= val_bnd_q[15:8]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s4   <= h_c;
			s_s4   <= s_c;
			v_s4   <= hsd_s[DL].mx;
			key_s4 <= key_c;
			fb_s4  <= hsd_s[DL].fb;
			fg_s4  <= hsd_s[DL].fg;
			fr_s4  <= hsd_s[DL].fr;
			bb_s4  <= hsd_s[DL].bb;
			bg_s4  <= hsd_s[DL].bg;
			br_s4  <= hsd_s[DL].br;
		end
	end

	// correction lanes; in value mode the blue lane carries V
	logic [7:0] lv_b, lv_g, lv_r;
	ckg_corr u_corr_b (.clk(clk), .en(en), .x(vmode_q ? v_s4 : fb_s4), .cfg(corr_cfg),
		.level(lv_b));
	ckg_corr u_corr_g (.clk(clk), .en(en), .x(fg_s4), .cfg(corr_cfg), .level(lv_g));
	ckg_corr u_corr_r (.clk(clk), .en(en), .x(fr_s4), .cfg(corr_cfg), .level(lv_r));

	corr_side_t csd_s [1:CL];
	always_ff @(posedge clk) begin
		if (en) begin
			csd_s[1] <= '{h: h_s4, s: s_s4, bb: bb_s4, bg: bg_s4, br: br_s4, key: key_s4};
			for (int i = 2; i <= CL; i++) csd_s[i] <= csd_s[i-1];
		end
	end

	// s5 sector and hue remainder
	ckg_pkg::ckg_sec_t sec_c;
	logic [7:0] base_c;
	ckg_pkg::ckg_sec_t sec_s5, sec_s6, sec_s7, sec_s8, sec_s9;
	logic [5:0] rh_s5;
	logic [7:0] s_s5, v_s5, v_s6, v_s7;
	tail_t      tl_s5, tl_s6, tl_s7, tl_s8, tl_s9;

	always_comb begin
		if (csd_s[CL].h < 8'd30) begin
			sec_c = ckg_pkg::SEC_RED_YEL; base_c = 8'd0;
		end else if (csd_s[CL].h < 8'd60) begin
			sec_c = ckg_pkg::SEC_YEL_GRN; base_c = 8'd30;
		end else if (csd_s[CL].h < 8'd90) begin
			sec_c = ckg_pkg::SEC_GRN_CYN; base_c = 8'd60;
		end else if (csd_s[CL].h < 8'd120) begin
			sec_c = ckg_pkg::SEC_CYN_BLU; base_c = 8'd90;
		end else if (csd_s[CL].h < 8'd150) begin
			sec_c = ckg_pkg::SEC_BLU_MAG; base_c = 8'd120;
		end else begin
			sec_c = ckg_pkg::SEC_MAG_RED; base_c = 8'd150;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sec_s5 <= sec_c;
			rh_s5  <= 6'(csd_s[CL].h - base_c) << 1;
			s_s5   <= csd_s[CL].s;
			v_s5   <= lv_b;
			tl_s5  <= '{key: csd_s[CL].key, bb: csd_s[CL].bb, bg: csd_s[CL].bg,
				br: csd_s[CL].br, lb: lv_b, lg: lv_g, lr: lv_r};
		end
	end

	// s6..s9 p, q, t with rounded constant divisions
	logic [13:0] sr_s6, srt_s6;
	logic [7:0]  vs_s6;
	logic [16:0] pn_s7, pn_s8;
	logic [22:0] qn_s7, tn_s7, qn_s8, tn_s8;
	logic [8:0]  p0_s8, q0_s8, t0_s8;
	logic [7:0]  p_s9, q_s9, t_s9;
	logic [25:0] pe;
	logic [31:0] qe, te;
	logic [16:0] prm;
	logic [22:0] qrm, trm;

	assign pe  = 26'(pn_s7) * 26'd257;
	assign qe  = 32'(qn_s7) * 32'd274;
	assign te  = 32'(tn_s7) * 32'd274;
	assign prm = pn_s8 - 17'(p0_s8) * 17'd510;
	assign qrm = qn_s8 - 23'(q0_s8) * 23'd30600;
	assign trm = tn_s8 - 23'(t0_s8) * 23'd30600;

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s6  <= 14'(s_s5) * 14'(rh_s5);
			srt_s6 <= 14'(s_s5) * 14'(6'd60 - rh_s5);
			vs_s6  <= 8'd255 - s_s5;
			v_s6   <= v_s5;
			sec_s6 <= sec_s5;
			tl_s6  <= tl_s5;

			pn_s7  <= ((17'(v_s6) * 17'(vs_s6)) << 1) + 17'd255;
			qn_s7  <= ((23'(v_s6) * 23'(14'd15300 - sr_s6)) << 1) + 23'd15300;
			tn_s7  <= ((23'(v_s6) * 23'(14'd15300 - srt_s6)) << 1) + 23'd15300;
			v_s7   <= v_s6;
			sec_s7 <= sec_s6;
			tl_s7  <= tl_s6;

			pn_s8  <= pn_s7;
			qn_s8  <= qn_s7;
			tn_s8  <= tn_s7;
			p0_s8  <= 9'(pe >> 17);
			q0_s8  <= 9'(qe >> 23);
			t0_s8  <= 9'(te >> 23);
			sec_s8 <= sec_s7;
			tl_s8  <= tl_s7;

			p_s9   <= 8'((prm >= 17'd510) ? p0_s8 + 9'd1 : p0_s8);
			q_s9   <= 8'((qrm >= 23'd30600) ? q0_s8 + 9'd1 : q0_s8);
			t_s9   <= 8'((trm >= 23'd30600) ? t0_s8 + 9'd1 : t0_s8);
			sec_s9 <= sec_s8;
			tl_s9  <= tl_s8;
		end
	end

	// value channel travels in the tail as the corrected blue lane
	logic [7:0] v_s9;
	assign v_s9 = tl_s9.lb;

	// s10 output register
	logic [7:0] hb_c, hg_c, hr_c;
	logic [7:0] ob_s10, og_s10, or_s10;
	logic       key_s10;

	always_comb begin
		case (sec_s9)
			ckg_pkg::SEC_RED_YEL: begin hr_c = v_s9; hg_c = t_s9; hb_c = p_s9; end
			ckg_pkg::SEC_YEL_GRN: begin hr_c = q_s9; hg_c = v_s9; hb_c = p_s9; end
			ckg_pkg::SEC_GRN_CYN: begin hr_c = p_s9; hg_c = v_s9; hb_c = t_s9; end
			ckg_pkg::SEC_CYN_BLU: begin hr_c = p_s9; hg_c = q_s9; hb_c = v_s9; end
			ckg_pkg::SEC_BLU_MAG: begin hr_c = t_s9; hg_c = p_s9; hb_c = v_s9; end
			default:              begin hr_c = v_s9; hg_c = p_s9; hb_c = q_s9; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			key_s10 <= tl_s9.key;
			if (tl_s9.key) begin
				ob_s10 <= tl_s9.bb;
				og_s10 <= tl_s9.bg;
				or_s10 <= tl_s9.br;
			end else if (vmode_q) begin
				ob_s10 <= hb_c;
				og_s10 <= hg_c;
				or_s10 <= hr_c;
			end else begin
				ob_s10 <= tl_s9.lb;
				og_s10 <= tl_s9.lg;
				or_s10 <= tl_s9.lr;
			end
		end
	end

	assign pix_out.out_blue  = ob_s10;
	assign pix_out.out_green = og_s10;
	assign pix_out.out_red   = or_s10;
	assign pix_out.keyed     = key_s10;
endmodule

// ===== verif/tb_chroma_key_gamma_composite_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chroma_key_gamma_composite_unit
// Self-checking bench for the chroma-key composite unit. Pixel pairs go in
// through a valid/ready channel, each composited pixel that comes out is
// compared against a bit-exact software predictor of the key test and the
// gamma/contrast/brightness correction. Registers are set over the APB port
// between phases, both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_chroma_key_gamma_composite_unit;

	typedef struct {
		logic [7:0] fb, fg, fr, bb, bgc, br;
	} pair_t;

	typedef struct {
		logic [7:0] b, g, r;
		logic       keyed;
	} pix_t;

	typedef struct {
		pair_t pair;
		bit    typed;
		pix_t  res;
	} row_t;

	localparam longint unsigned UNIT = 64'd1 << 16;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	ckg_in_if  pix_in ();
	ckg_out_if pix_out ();

	chroma_key_gamma_composite_unit dut (
		.clk(clk), .arst_n(arst_n), .pix_in(pix_in), .pix_out(pix_out),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// predictor copy of the registers
	longint unsigned contrast, bright, gam, v_only, hue_b, sat_b, val_b;
	longint unsigned root_chain [1:16];

	pix_t pending_pix [$];
	int   n_err;
	bit   calm;
	bit   rx_hold_req;
	int   rx_hold_cnt;

	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned res, bt, w;
		res = 0;
		w = v;
		bt = 64'd1 << 62;
		while (bt > w) bt = bt >> 2;
		while (bt != 0) begin
			if (w >= res + bt) begin
				w = w - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned rnd_div(longint unsigned num, longint unsigned den);
		return (2 * num + den) / (2 * den);
	endfunction

	function automatic longint unsigned corrected_level(longint unsigned x);
		longint unsigned p, s, cv, off, t, m, frac, mag, e, k, f, r;
		int n;
		if (x == 0) begin
			p = (gam == 0) ? UNIT : 0;
		end else begin
			t = (x * UNIT + 127) / 255;
			if (t == 0) t = 1;
			n = 0;
			while ((t >> (n + 1)) != 0) n++;
			m = t << (16 - n);
			frac = 0;
			for (int i = 1; i <= 16; i++) begin
				m = (m * m) >> 16;
				if (m >= 2 * UNIT) begin
					m = m >> 1;
					frac = frac | (64'd1 << (16 - i));
				end
			end
			mag = longint'(16 - n) * UNIT - frac;
			e = (mag * gam + 50) / 100;
			k = e >> 16;
			f = e & (UNIT - 1);
			r = UNIT;
			for (int i = 1; i <= 16; i++)
				if ((f >> (16 - i)) & 1) r = (r * root_chain[i] + (UNIT >> 1)) >> 16;
			if (k >= 62) p = 0;
			else if (k == 0) p = r;
			else p = (r + (64'd1 << (k - 1))) >> k;
		end
		cv = (contrast * p + 50) / 100;
		if (bright >= 100) begin
			off = ((bright - 100) * UNIT + 50) / 100;
			s = cv + off;
		end else begin
			off = ((100 - bright) * UNIT + 50) / 100;
			s = (cv >= off) ? cv - off : 0;
		end
		if (s > UNIT) s = UNIT;
		return (s * 255 + (UNIT >> 1)) >> 16;
	endfunction

	function automatic bit within_bounds(longint unsigned x, longint unsigned bnd);
		return x >= (bnd & 8'hFF) && x <= ((bnd >> 8) & 8'hFF);
	endfunction

	function automatic pix_t composite_pixel(pair_t pr);
		pix_t o;
		longint unsigned b, g, r, mx, mn, d, num, h, s, v, deg, sec, rh, pp, qq, tt, vc;
		b = pr.fb; g = pr.fg; r = pr.fr;
		mx = r; mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		v = mx;
		s = (mx == 0) ? 0 : rnd_div(255 * d, mx);
		h = 0;
		if (d != 0) begin
			// ties on max resolve red, then green, then blue
			if (mx == r) num = (g >= b) ? 30 * (g - b) : 180 * d - 30 * (b - g);
			else if (mx == g) num = (b >= r) ? 60 * d + 30 * (b - r) : 60 * d - 30 * (r - b);
			else num = (r >= g) ? 120 * d + 30 * (r - g) : 120 * d - 30 * (g - r);
			h = rnd_div(num, d);
			if (h >= 180) h = h - 180;
		end
		if (within_bounds(h, hue_b) && within_bounds(s, sat_b) && within_bounds(v, val_b)) begin
			o.b = pr.bb; o.g = pr.bgc; o.r = pr.br; o.keyed = 1'b1;
			return o;
		end
		o.keyed = 1'b0;
		if (v_only != 0) begin
			vc = corrected_level(v);
			deg = (2 * h) % 360;
			sec = deg / 60;
			rh = deg % 60;
			pp = rnd_div(vc * (255 - s), 255);
			qq = rnd_div(vc * (255 * 60 - s * rh), 255 * 60);
			tt = rnd_div(vc * (255 * 60 - s * (60 - rh)), 255 * 60);
			case (sec)
				0: begin o.r = vc[7:0]; o.g = tt[7:0]; o.b = pp[7:0]; end
				1: begin o.r = qq[7:0]; o.g = vc[7:0]; o.b = pp[7:0]; end
				2: begin o.r = pp[7:0]; o.g = vc[7:0]; o.b = tt[7:0]; end
				3: begin o.r = pp[7:0]; o.g = qq[7:0]; o.b = vc[7:0]; end
				4: begin o.r = tt[7:0]; o.g = pp[7:0]; o.b = vc[7:0]; end
				default: begin o.r = vc[7:0]; o.g = pp[7:0]; o.b = qq[7:0]; end
			endcase
		end else begin
			o.b = 8'(corrected_level(b));
			o.g = 8'(corrected_level(g));
			o.r = 8'(corrected_level(r));
		end
		return o;
	endfunction

	task automatic reg_write(input ckg_pkg::ckg_reg_t idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 5'(idx) << 2; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			ckg_pkg::REG_CONTRAST:   contrast = val & 8'hFF;
			ckg_pkg::REG_BRIGHTNESS: bright = val & 8'hFF;
			ckg_pkg::REG_GAMMA:      gam = val & 8'hFF;
			ckg_pkg::REG_VALUE_ONLY: v_only = val & 1;
			ckg_pkg::REG_HUE_BOUNDS: hue_b = val & 16'hFFFF;
			ckg_pkg::REG_SAT_BOUNDS: sat_b = val & 16'hFFFF;
			ckg_pkg::REG_VAL_BOUNDS: val_b = val & 16'hFFFF;
			default: ;
		endcase
	endtask

	task automatic drain();
		pix_in.valid <= 1'b0;
		wait (pending_pix.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_regs(input int c, input int b, input int g, input int vm,
			input int hb, input int sb, input int vb);
		drain();
		reg_write(ckg_pkg::REG_CONTRAST, c);
		reg_write(ckg_pkg::REG_BRIGHTNESS, b);
		reg_write(ckg_pkg::REG_GAMMA, g);
		reg_write(ckg_pkg::REG_VALUE_ONLY, vm);
		reg_write(ckg_pkg::REG_HUE_BOUNDS, hb);
		reg_write(ckg_pkg::REG_SAT_BOUNDS, sb);
		reg_write(ckg_pkg::REG_VAL_BOUNDS, vb);
	endtask

	task automatic send_pair(input pair_t pr, input bit typed, input pix_t res);
		if (!calm && $urandom_range(99) < 28) begin
			pix_in.valid <= 1'b0;
			@(posedge clk);
		end
		pix_in.valid <= 1'b1;
		pix_in.fg_blue <= pr.fb; pix_in.fg_green <= pr.fg; pix_in.fg_red <= pr.fr;
		pix_in.bg_blue <= pr.bb; pix_in.bg_green <= pr.bgc; pix_in.bg_red <= pr.br;
		do @(posedge clk); while (!pix_in.ready);
		pending_pix.push_back(typed ? res : composite_pixel(pr));
	endtask

	function automatic pair_t rand_pair(bit greenish);
		pair_t pr;
		pr.fb = $urandom; pr.fg = $urandom; pr.fr = $urandom;
		pr.bb = $urandom; pr.bgc = $urandom; pr.br = $urandom;
		if (greenish) begin
			pr.fg = $urandom_range(120, 255);
			pr.fr = $urandom_range(0, 90);
			pr.fb = $urandom_range(0, 90);
		end
		return pr;
	endfunction

	// output side: random stalls, or a long hold-off when asked for
	always @(posedge clk) begin
		if (rx_hold_req) begin
			rx_hold_req = 1'b0;
			rx_hold_cnt = 300;
		end
		if (rx_hold_cnt > 0) begin
			rx_hold_cnt = rx_hold_cnt - 1;
			pix_out.ready <= 1'b0;
		end else begin
			pix_out.ready <= calm ? 1'b1 : ($urandom_range(99) >= 22);
		end
	end

	always @(posedge clk) begin
		pix_t want;
		if (arst_n && pix_out.valid && pix_out.ready) begin
			if (pending_pix.size() == 0) begin
				$display("%0t unexpected transfer: b=%h g=%h r=%h keyed=%b", $time,
					pix_out.out_blue, pix_out.out_green, pix_out.out_red, pix_out.keyed);
				n_err++;
			end else begin
				want = pending_pix.pop_front();
				if (pix_out.out_blue !== want.b || pix_out.out_green !== want.g ||
						pix_out.out_red !== want.r || pix_out.keyed !== want.keyed) begin
					$display("%0t mismatch: expected b=%h g=%h r=%h keyed=%b, %s",
						$time, want.b, want.g, want.r, want.keyed,
						$sformatf("actual b=%h g=%h r=%h keyed=%b", pix_out.out_blue,
						pix_out.out_green, pix_out.out_red, pix_out.keyed));
					n_err++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("[chroma_key_gamma_composite_unit] ERROR");
		$finish;
	end

	initial begin
		row_t  rows [$];
		pix_t  none;
		pair_t pr;
		longint unsigned a;
		int    hlo, hhi;

		n_err = 0; calm = 1'b0; rx_hold_req = 1'b0; rx_hold_cnt = 0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		pix_in.valid = 1'b0;
		pix_in.fg_blue = '0; pix_in.fg_green = '0; pix_in.fg_red = '0;
		pix_in.bg_blue = '0; pix_in.bg_green = '0; pix_in.bg_red = '0;
		pix_out.ready = 1'b0;
		contrast = 100; bright = 100; gam = 100; v_only = 0;
		hue_b = 0; sat_b = 0; val_b = 0;
		none = '{b: 8'h00, g: 8'h00, r: 8'h00, keyed: 1'b0};

		a = floor_root((UNIT >> 1) << 16);
		for (int i = 1; i <= 16; i++) begin
			root_chain[i] = a;
			a = floor_root(a << 16);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// black keys on the reset bounds, white is unity-corrected to full scale
		rows.push_back('{'{8'h00, 8'h00, 8'h00, 8'h12, 8'hA5, 8'hFF}, 1'b1,
			'{b: 8'h12, g: 8'hA5, r: 8'hFF, keyed: 1'b1}});
		rows.push_back('{'{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00}, 1'b1,
			'{b: 8'hFF, g: 8'hFF, r: 8'hFF, keyed: 1'b0}});
		rows.push_back('{'{8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0, none});
		rows.push_back('{'{8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'h55}, 1'b0, none});
		rows.push_back('{'{8'hFF, 8'h00, 8'h00, 8'hAA, 8'h55, 8'hAA}, 1'b0, none});
		rows.push_back('{'{8'h80, 8'h80, 8'h80, 8'h01, 8'h02, 8'h03}, 1'b0, none});
		rows.push_back('{'{8'h01, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00}, 1'b0, none});
		// hue rounding to 180 wraps to 0
		rows.push_back('{'{8'h01, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00}, 1'b0, none});
		rows.push_back('{'{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00}, 1'b0, none});
		rows.push_back('{'{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, none});
		rows.push_back('{'{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00}, 1'b0, none});
		rows.push_back('{'{8'h40, 8'hC0, 8'h10, 8'h7F, 8'h80, 8'h7F}, 1'b0, none});

		foreach (rows[i]) send_pair(rows[i].pair, rows[i].typed, rows[i].res);

		// zero gamma, value-only correction, empty hue bounds
		set_regs(100, 100, 0, 1, 16'h050A, 16'hFF00, 16'hFF00);
		foreach (rows[i]) send_pair(rows[i].pair, 1'b0, none);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_regs(200, 200, 200, 0, 16'h5028, 16'hFF50, 16'hFF3C);
				1: set_regs(0, 0, 0, 1, 16'hB400, 16'hFF00, 16'h3F00);
				2: set_regs(255, 255, 255, 1, 16'h5028, 16'hFF50, 16'hFF3C);
				3: begin
					hlo = $urandom_range(0, 180);
					hhi = $urandom_range(0, 180);
					set_regs($urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 1), (hhi << 8) | hlo,
						$urandom_range(0, 65535), $urandom_range(0, 65535));
				end
				4: set_regs(137, 63, 45, 0, 16'h5028, 16'hFF50, 16'hFF3C);
				default: set_regs(100, 100, 100, 1, 16'hB4AA, 16'hFF00, 16'hFF00);
			endcase
			calm = (ph == 4);
			for (int i = 0; i < 66; i++) begin
				if (ph == 2 && i == 5) rx_hold_req = 1'b1;
				if (ph == 3 && i == 33) begin
					pix_in.valid <= 1'b0;
					wait (pending_pix.size() == 0);
					@(posedge clk);
				end
				pr = rand_pair($urandom_range(99) < 55);
				send_pair(pr, 1'b0, none);
			end
		end
		calm = 1'b0;

		pix_in.valid <= 1'b0;
		wait (pending_pix.size() == 0);
		repeat (60) @(posedge clk);
		if (n_err == 0 && pending_pix.size() == 0) begin
			$display("[chroma_key_gamma_composite_unit] OK");
		end else begin
			$display("[chroma_key_gamma_composite_unit] ERROR");
		end
		$finish;
	end

endmodule
